/* src/olba_pkg.sv */
// One-lane bridge arbiter: shared types and constants.
// Transaction structs, command, verdict, cause and turn codes, register indexes.
// No dependencies.
`default_nettype none

package olba_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ON_BRIDGE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CONSECUTIVE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_WEIGHT      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_HEIGHT      = 2'd3;

  localparam logic [3:0] RST_MAX_ON_BRIDGE   = 4'd3;
  localparam logic [7:0] RST_MAX_CONSECUTIVE = 8'd5;
  localparam logic [7:0] RST_MAX_WEIGHT      = 8'd20;
  localparam logic [3:0] RST_MAX_HEIGHT      = 4'd4;

  localparam logic [2:0] CMD_ARRIVE      = 3'd0;
  localparam logic [2:0] CMD_REQUEST     = 3'd1;
  localparam logic [2:0] CMD_LEAVE       = 3'd2;
  localparam logic [2:0] CMD_SET_SENSOR  = 3'd3;
  localparam logic [2:0] CMD_SET_BARRIER = 3'd4;
  localparam logic [2:0] CMD_FAULT_BLOCK = 3'd5;
  localparam logic [2:0] CMD_RESUME      = 3'd6;

  localparam logic [2:0] VERDICT_ACK        = 3'd0;
  localparam logic [2:0] VERDICT_GRANTED    = 3'd1;
  localparam logic [2:0] VERDICT_WAIT       = 3'd2;
  localparam logic [2:0] VERDICT_REJ_WEIGHT = 3'd3;
  localparam logic [2:0] VERDICT_REJ_HEIGHT = 3'd4;
  localparam logic [2:0] VERDICT_REJ_FAULT  = 3'd5;

  localparam logic [2:0] CAUSE_NONE       = 3'd0;
  localparam logic [2:0] CAUSE_WEIGHT     = 3'd1;
  localparam logic [2:0] CAUSE_HEIGHT     = 3'd2;
  localparam logic [2:0] CAUSE_MECHANICAL = 3'd3;
  localparam logic [2:0] CAUSE_COMPONENT  = 3'd4;

  localparam logic [1:0] TURN_LEFT  = 2'd0;
  localparam logic [1:0] TURN_RIGHT = 2'd1;
  localparam logic [1:0] TURN_NONE  = 2'd2;

  typedef struct packed {
    logic [2:0] command;
    logic       direction;
    logic [7:0] vehicle_weight;
    logic [3:0] vehicle_height;
    logic       severe_fault;
    logic       component_ok;
  } event_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic        blocked;
    logic [2:0]  block_cause;
    logic [1:0]  turn;
    logic [3:0]  on_bridge_count;
    logic [7:0]  consecutive_count;
    logic [15:0] total_crossed;
  } result_t;

endpackage

`default_nettype wire

/* src/olba_event_if.sv */
// Event channel of the one-lane bridge arbiter: valid, ready and payload.
// Depends on olba_pkg.
`default_nettype none

interface olba_event_if;
  logic              valid;
  logic              ready;
  olba_pkg::event_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/olba_result_if.sv */
// Result channel of the one-lane bridge arbiter: valid, ready and payload.
// Depends on olba_pkg.
`default_nettype none

interface olba_result_if;
  logic              valid;
  logic              ready;
  olba_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/one_lane_bridge_arbiter.sv */
// One-lane bridge arbiter: event decode, state update and result buffer.
// Depends on olba_pkg, olba_event_if and olba_result_if.
//
// The arbiter takes one event per clock and answers each with exactly one result
// transaction, registered in the result buffer on acceptance. Every event is
// resolved in a single pass of compares and counter updates between the state
// registers and a two-entry result buffer; the buffer lets the block keep taking
// events while one finished result waits on the output, and events stall only when
// both entries are full. Configuration writes take effect at the clock edge of the
// write and are meant to be done while no transaction is in flight.
`default_nettype none

module one_lane_bridge_arbiter #(
  parameter int COUNT_WIDTH = 8,
  parameter int TOTAL_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  olba_event_if.sink                              events,
  olba_result_if.source                           results,
  input  wire logic                               cfg_we,
  input  wire logic [olba_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [olba_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

  // configuration
  logic [3:0] max_on_bridge;
  logic [7:0] max_consecutive;
  logic [7:0] max_weight;
  logic [3:0] max_height;

  // arbiter state
  logic [3:0]             crossing [2];
  logic [COUNT_WIDTH-1:0] waiting  [2];
  logic [COUNT_WIDTH-1:0] run      [2];
  logic [1:0]             current_turn;
  logic                   suspended;
  logic [2:0]             cause_code;
  logic [1:0]             sensor_ok;
  logic [1:0]             barrier_ok;
  logic [TOTAL_WIDTH-1:0] total;

  logic [3:0]             crossing_next [2];
  logic [COUNT_WIDTH-1:0] waiting_next  [2];
  logic [COUNT_WIDTH-1:0] run_next      [2];
  logic [1:0]             current_turn_next;
  logic                   suspended_next;
  logic [2:0]             cause_code_next;
  logic [1:0]             sensor_ok_next;
  logic [1:0]             barrier_ok_next;
  logic [TOTAL_WIDTH-1:0] total_next;
  logic [2:0]             verdict;

  // result buffer
  olba_pkg::result_t head;
  olba_pkg::result_t spill;
  logic              head_valid;
  logic              spill_valid;
  olba_pkg::result_t result_new;

  olba_pkg::event_t ev;
  logic             accept;
  logic             pop;
  logic             me;
  logic             other;
  logic [2:0]       reject_verdict;
  logic [2:0]       reject_cause;
  logic             my_turn;
  logic             room;
  logic             run_ok;
  logic [3:0]       crossing_dec;
  logic [CMP_W-1:0]       run_wide;
  logic [CMP_W-1:0]       max_consec_wide;
  logic [COUNT_WIDTH+7:0] run_out_ext;
  logic [TOTAL_WIDTH+15:0] total_out_ext;

  assign ev     = events.data;
  assign accept = events.valid && events.ready;
  assign pop    = head_valid && results.ready;
  assign me     = ev.direction;
  assign other  = ~ev.direction;

  assign events.ready  = !rst && !spill_valid;
  assign results.valid = head_valid;
  assign results.data  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_on_bridge   <= olba_pkg::RST_MAX_ON_BRIDGE;
      max_consecutive <= olba_pkg::RST_MAX_CONSECUTIVE;
      max_weight      <= olba_pkg::RST_MAX_WEIGHT;
      max_height      <= olba_pkg::RST_MAX_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        olba_pkg::REG_MAX_ON_BRIDGE:   max_on_bridge   <= cfg_data[3:0];
        olba_pkg::REG_MAX_CONSECUTIVE: max_consecutive <= cfg_data[7:0];
        olba_pkg::REG_MAX_WEIGHT:      max_weight      <= cfg_data[7:0];
        olba_pkg::REG_MAX_HEIGHT:      max_height      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ev.vehicle_weight > max_weight) begin
      reject_verdict = olba_pkg::VERDICT_REJ_WEIGHT;
      reject_cause   = olba_pkg::CAUSE_WEIGHT;
    end else if (ev.vehicle_height > max_height) begin
      reject_verdict = olba_pkg::VERDICT_REJ_HEIGHT;
      reject_cause   = olba_pkg::CAUSE_HEIGHT;
    end else if (ev.severe_fault) begin
      reject_verdict = olba_pkg::VERDICT_REJ_FAULT;
      reject_cause   = olba_pkg::CAUSE_MECHANICAL;
    end else begin
      reject_verdict = olba_pkg::VERDICT_ACK;
      reject_cause   = olba_pkg::CAUSE_NONE;
    end
  end

  assign run_wide        = CMP_W'(run[me]);
  assign max_consec_wide = CMP_W'(max_consecutive);
  assign my_turn = (current_turn == {1'b0, me}) || (current_turn == olba_pkg::TURN_NONE);
  assign room    = crossing[me] < max_on_bridge;
  assign run_ok  = (waiting[other] == '0) || (run_wide < max_consec_wide);
  assign crossing_dec = crossing[me] - 4'd1;

  always_comb begin
    crossing_next     = crossing;
    waiting_next      = waiting;
    run_next          = run;
    current_turn_next = current_turn;
    suspended_next    = suspended;
    cause_code_next   = cause_code;
    sensor_ok_next    = sensor_ok;
    barrier_ok_next   = barrier_ok;
    total_next        = total;
    verdict           = olba_pkg::VERDICT_ACK;

    case (ev.command)
      olba_pkg::CMD_ARRIVE: begin
        if (waiting[me] != '1) waiting_next[me] = waiting[me] + 1'b1;
      end
      olba_pkg::CMD_REQUEST: begin
        if (!sensor_ok[me] || !barrier_ok[me]) begin
          verdict = olba_pkg::VERDICT_WAIT;
        end else if (reject_verdict != olba_pkg::VERDICT_ACK) begin
          verdict = reject_verdict;
          if (waiting[me] != '0) waiting_next[me] = waiting[me] - 1'b1;
          if (!suspended) begin
            suspended_next  = 1'b1;
            cause_code_next = reject_cause;
          end
        end else if (suspended || !my_turn || (crossing[other] != 4'd0) || !room ||
                     !run_ok) begin
          verdict = olba_pkg::VERDICT_WAIT;
        end else begin
          verdict = olba_pkg::VERDICT_GRANTED;
          if (current_turn == olba_pkg::TURN_NONE) current_turn_next = {1'b0, me};
          if (waiting[me] != '0) waiting_next[me] = waiting[me] - 1'b1;
          crossing_next[me] = crossing[me] + 4'd1;
          if (waiting[other] != '0 && run[me] != '1) run_next[me] = run[me] + 1'b1;
        end
      end
      olba_pkg::CMD_LEAVE: begin
        if (crossing[me] != 4'd0) begin
          crossing_next[me] = crossing_dec;
          if (total != '1) total_next = total + 1'b1;
          if (crossing_dec == 4'd0) begin
            if (run_wide >= max_consec_wide) run_next[me] = '0;
            if (waiting[other] != '0) begin
              current_turn_next = {1'b0, other};
            end else begin
              current_turn_next = olba_pkg::TURN_NONE;
              run_next[me]      = '0;
            end
          end
        end
      end
      olba_pkg::CMD_SET_SENSOR:  sensor_ok_next[me]  = ev.component_ok;
      olba_pkg::CMD_SET_BARRIER: barrier_ok_next[me] = ev.component_ok;
      olba_pkg::CMD_FAULT_BLOCK: begin
        if (!suspended) begin
          suspended_next  = 1'b1;
          cause_code_next = olba_pkg::CAUSE_COMPONENT;
        end
      end
      olba_pkg::CMD_RESUME: begin
        suspended_next  = 1'b0;
        cause_code_next = olba_pkg::CAUSE_NONE;
        sensor_ok_next  = 2'b11;
        barrier_ok_next = 2'b11;
      end
      default: ;
    endcase
  end

  assign run_out_ext   = {8'd0, run_next[me]};
  assign total_out_ext = {16'd0, total_next};

  always_comb begin
    result_new.verdict           = verdict;
    result_new.blocked           = suspended_next;
    result_new.block_cause       = cause_code_next;
    result_new.turn              = current_turn_next;
    result_new.on_bridge_count   = crossing_next[me];
    result_new.consecutive_count = run_out_ext[7:0];
    result_new.total_crossed     = total_out_ext[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crossing     <= '{default: '0};
      waiting      <= '{default: '0};
      run          <= '{default: '0};
      current_turn <= olba_pkg::TURN_NONE;
      suspended    <= 1'b0;
      cause_code   <= olba_pkg::CAUSE_NONE;
      sensor_ok    <= 2'b11;
      barrier_ok   <= 2'b11;
      total        <= '0;
    end else if (accept) begin
      crossing     <= crossing_next;
      waiting      <= waiting_next;
      run          <= run_next;
      current_turn <= current_turn_next;
      suspended    <= suspended_next;
      cause_code   <= cause_code_next;
      sensor_ok    <= sensor_ok_next;
      barrier_ok   <= barrier_ok_next;
      total        <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spill_valid <= 1'b0;
    end else if (pop) begin
      if (spill_valid) begin
        head <= spill;
        if (accept) begin
          spill <= result_new;
        end else begin
          spill_valid <= 1'b0;
        end
      end else if (accept) begin
        head <= result_new;
      end else begin
        head_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!head_valid) begin
        head       <= result_new;
        head_valid <= 1'b1;
      end else begin
        spill       <= result_new;
        spill_valid <= 1'b1;
      end
    end
  end

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    !((crossing[0] != 4'd0) && (crossing[1] != 4'd0)))
    else $error("vehicles crossing from both sides");

  a_cause_matches_block: assert property (@(posedge clk) disable iff (rst)
    suspended == (cause_code != olba_pkg::CAUSE_NONE))
    else $error("block flag and cause disagree");

  a_spill_needs_head: assert property (@(posedge clk) disable iff (rst)
    spill_valid |-> head_valid)
    else $error("result buffer holds spill without head");

  a_grant_sets_turn: assert property (@(posedge clk) disable iff (rst)
    (accept && verdict == olba_pkg::VERDICT_GRANTED) |=>
      (current_turn == {1'b0, $past(me)}))
    else $error("grant left turn on the other side");

endmodule

`default_nettype wire
